>>> hdl/sqlsel_pkg.sv
// Package with token kinds, grammar positions and the transition function of the SELECT recognizer.
`timescale 1ns / 1ps
package sqlsel_pkg;

  localparam int MAX_NESTING = 16;
  localparam int NUM_KINDS = 27;
  localparam int KIND_W = 5;
  localparam int DEPTH_W = 5;
  localparam int MASK_W = 27;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] T_SELECT   = 5'd0;
  localparam logic [KIND_W-1:0] T_DISTINCT = 5'd1;
  localparam logic [KIND_W-1:0] T_STAR     = 5'd2;
  localparam logic [KIND_W-1:0] T_IDENT    = 5'd3;
  localparam logic [KIND_W-1:0] T_WS       = 5'd4;
  localparam logic [KIND_W-1:0] T_COMMA    = 5'd5;
  localparam logic [KIND_W-1:0] T_FROM     = 5'd6;
  localparam logic [KIND_W-1:0] T_AS       = 5'd7;
  localparam logic [KIND_W-1:0] T_WHERE    = 5'd8;
  localparam logic [KIND_W-1:0] T_ORDER    = 5'd9;
  localparam logic [KIND_W-1:0] T_GROUP    = 5'd10;
  localparam logic [KIND_W-1:0] T_END      = 5'd11;
  localparam logic [KIND_W-1:0] T_NOT      = 5'd12;
  localparam logic [KIND_W-1:0] T_LB       = 5'd13;
  localparam logic [KIND_W-1:0] T_RB       = 5'd14;
  localparam logic [KIND_W-1:0] T_EQ       = 5'd15;
  localparam logic [KIND_W-1:0] T_GE       = 5'd19;
  localparam logic [KIND_W-1:0] T_STRING   = 5'd20;
  localparam logic [KIND_W-1:0] T_INTEGER  = 5'd21;
  localparam logic [KIND_W-1:0] T_AND      = 5'd22;
  localparam logic [KIND_W-1:0] T_OR       = 5'd23;
  localparam logic [KIND_W-1:0] T_BY       = 5'd24;
  localparam logic [KIND_W-1:0] T_ASC      = 5'd25;
  localparam logic [KIND_W-1:0] T_DESC     = 5'd26;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONTINUE = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_ERROR    = 3'd2,
    ST_TOO_DEEP = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    P_IDLE, P_START, P_SEL, P_DIST, P_DIST_D, P_PROJ, P_STAR, P_FROM, P_FROM_F,
    P_FROM_W, P_PID, P_PID_SP, P_AS, P_AS_W, P_PCOMMA, P_PCOMMA_W, P_PAS,
    P_PAS_SP, P_FID, P_FID_SP, P_FCOMMA, P_FCOMMA_W, P_WHERE_K, P_EXPR, P_NOT,
    P_EPOS, P_OPEN, P_WID, P_COMP, P_WCOMP, P_RVAL, P_CRV, P_CSP, P_CONJ,
    P_CLOSED, P_GRP_K, P_GRP_W, P_GRP_B, P_GRP_BW, P_GID, P_GID_SP, P_GCOMMA,
    P_GCOMMA_W, P_ORD_K, P_ORD_W, P_ORD_B, P_ORD_BW, P_OID, P_OID_SP, P_OAD,
    P_OAD_SP, P_OCOMMA, P_OCOMMA_W
  } pos_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_GOTO,
    ACT_ACCEPT,
    ACT_OPEN,
    ACT_CLOSE
  } act_t;

  typedef struct packed {
    act_t act;
    pos_t nxt;
  } trans_t;

  function automatic trans_t go(pos_t p);
    trans_t r;
    r.act = ACT_GOTO;
    r.nxt = p;
    return r;
  endfunction

  function automatic trans_t special(act_t a);
    trans_t r;
    r.act = a;
    r.nxt = P_IDLE;
    return r;
  endfunction

  function automatic trans_t where_tail(logic [KIND_W-1:0] k, logic nz);
    trans_t r;
    r = special(ACT_NONE);
    if (k == T_RB && nz) begin
      r = special(ACT_CLOSE);
    end else if (k == T_END && !nz) begin
      r = special(ACT_ACCEPT);
    end
    return r;
  endfunction

  function automatic trans_t after_from_list(logic [KIND_W-1:0] k);
    trans_t r;
    r = special(ACT_NONE);
    if (k == T_COMMA) r = go(P_FCOMMA);
    else if (k == T_WHERE) r = go(P_WHERE_K);
    else if (k == T_ORDER) r = go(P_ORD_K);
    else if (k == T_GROUP) r = go(P_GRP_K);
    else if (k == T_END) r = special(ACT_ACCEPT);
    return r;
  endfunction

  function automatic trans_t order_end(logic [KIND_W-1:0] k);
    trans_t r;
    r = special(ACT_NONE);
    if (k == T_COMMA) r = go(P_OCOMMA);
    else if (k == T_END) r = special(ACT_ACCEPT);
    return r;
  endfunction

  // The flag nz tells whether at least one bracket is open.
  function automatic trans_t trans(pos_t s, logic [KIND_W-1:0] k, logic nz);
    trans_t r;
    logic is_cmp;
    logic is_rval;
    is_cmp = k inside {[T_EQ:T_GE]};
    is_rval = k inside {T_IDENT, T_STRING, T_INTEGER};
    r = special(ACT_NONE);
    case (s)
      P_START: if (k == T_SELECT) r = go(P_SEL);
      P_SEL: if (k == T_WS) r = go(P_DIST);
      P_DIST: begin
        if (k == T_DISTINCT) r = go(P_DIST_D);
        else if (k == T_STAR) r = go(P_STAR);
        else if (k == T_IDENT) r = go(P_PID);
      end
      P_DIST_D: if (k == T_WS) r = go(P_PROJ);
      P_PROJ: begin
        if (k == T_STAR) r = go(P_STAR);
        else if (k == T_IDENT) r = go(P_PID);
      end
      P_STAR: if (k == T_WS) r = go(P_FROM);
      P_FROM: if (k == T_FROM) r = go(P_FROM_F);
      P_FROM_F: if (k == T_WS) r = go(P_FROM_W);
      P_FROM_W: if (k == T_IDENT) r = go(P_FID);
      P_PID: begin
        if (k == T_WS) r = go(P_PID_SP);
        else if (k == T_COMMA) r = go(P_PCOMMA);
      end
      P_PID_SP: begin
        if (k == T_FROM) r = go(P_FROM_F);
        else if (k == T_COMMA) r = go(P_PCOMMA);
        else if (k == T_AS) r = go(P_AS);
      end
      P_AS: if (k == T_WS) r = go(P_AS_W);
      P_AS_W: if (k == T_IDENT) r = go(P_PAS);
      P_PCOMMA: begin
        if (k == T_WS) r = go(P_PCOMMA_W);
        else if (k == T_IDENT) r = go(P_PID);
      end
      P_PCOMMA_W: if (k == T_IDENT) r = go(P_PID);
      P_PAS: begin
        if (k == T_WS) r = go(P_PAS_SP);
        else if (k == T_COMMA) r = go(P_PCOMMA);
      end
      P_PAS_SP: begin
        if (k == T_COMMA) r = go(P_PCOMMA);
        else if (k == T_FROM) r = go(P_FROM_F);
      end
      P_FID: begin
        if (k == T_WS) r = go(P_FID_SP);
        else r = after_from_list(k);
      end
      P_FID_SP: r = after_from_list(k);
      P_FCOMMA: begin
        if (k == T_WS) r = go(P_FCOMMA_W);
        else if (k == T_IDENT) r = go(P_FID);
      end
      P_FCOMMA_W: if (k == T_IDENT) r = go(P_FID);
      P_WHERE_K: if (k == T_WS) r = go(P_EXPR);
      P_EXPR, P_OPEN: begin
        if (s == P_OPEN && k == T_WS) r = go(P_EXPR);
        else if (k == T_NOT) r = go(P_NOT);
        else if (k == T_LB) r = special(ACT_OPEN);
        else if (k == T_IDENT) r = go(P_WID);
      end
      P_NOT: if (k == T_WS) r = go(P_EPOS);
      P_EPOS: begin
        if (k == T_LB) r = special(ACT_OPEN);
        else if (k == T_IDENT) r = go(P_WID);
      end
      P_WID: begin
        if (k == T_WS) r = go(P_COMP);
        else if (is_cmp) r = go(P_WCOMP);
      end
      P_COMP: if (is_cmp) r = go(P_WCOMP);
      P_WCOMP: begin
        if (k == T_WS) r = go(P_RVAL);
        else if (is_rval) r = go(P_CRV);
      end
      P_RVAL: if (is_rval) r = go(P_CRV);
      P_CRV: begin
        if (k == T_WS) r = go(P_CSP);
        else r = where_tail(k, nz);
      end
      P_CSP: begin
        if (k == T_AND || k == T_OR) r = go(P_CONJ);
        else r = where_tail(k, nz);
      end
      P_CONJ: if (k == T_WS) r = go(P_EXPR);
      P_CLOSED: r = where_tail(k, nz);
      P_GRP_K: if (k == T_WS) r = go(P_GRP_W);
      P_GRP_W: if (k == T_BY) r = go(P_GRP_B);
      P_GRP_B: if (k == T_WS) r = go(P_GRP_BW);
      P_GRP_BW: if (k == T_IDENT) r = go(P_GID);
      P_GID: begin
        if (k == T_WS) r = go(P_GID_SP);
        else if (k == T_COMMA) r = go(P_GCOMMA);
      end
      P_GID_SP: begin
        if (k == T_COMMA) r = go(P_GCOMMA);
        else if (k == T_ORDER) r = go(P_ORD_K);
        else if (k == T_END) r = special(ACT_ACCEPT);
      end
      P_GCOMMA: begin
        if (k == T_WS) r = go(P_GCOMMA_W);
        else if (k == T_IDENT) r = go(P_GID);
      end
      P_GCOMMA_W: if (k == T_IDENT) r = go(P_GID);
      P_ORD_K: if (k == T_WS) r = go(P_ORD_W);
      P_ORD_W: if (k == T_BY) r = go(P_ORD_B);
      P_ORD_B: if (k == T_WS) r = go(P_ORD_BW);
      P_ORD_BW: if (k == T_IDENT) r = go(P_OID);
      P_OID: begin
        if (k == T_WS) r = go(P_OID_SP);
        else r = order_end(k);
      end
      P_OID_SP: begin
        if (k == T_ASC || k == T_DESC) r = go(P_OAD);
        else r = order_end(k);
      end
      P_OAD: begin
        if (k == T_WS) r = go(P_OAD_SP);
        else r = order_end(k);
      end
      P_OAD_SP: r = order_end(k);
      P_OCOMMA: begin
        if (k == T_WS) r = go(P_OCOMMA_W);
        else if (k == T_IDENT) r = go(P_OID);
      end
      P_OCOMMA_W: if (k == T_IDENT) r = go(P_OID);
      default: r = special(ACT_NONE);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/sqlsel_if.sv
// Valid/ready channel interfaces for the token items and the result items.
`timescale 1ns / 1ps
interface sqlsel_tok_if;
  logic                             valid;
  logic                             ready;
  logic [sqlsel_pkg::KIND_W-1:0]    token_kind;
  logic                             first_of_statement;

  modport source (output valid, token_kind, first_of_statement, input ready);
  modport sink (input valid, token_kind, first_of_statement, output ready);
endinterface

interface sqlsel_res_if;
  logic                             valid;
  logic                             ready;
  logic [sqlsel_pkg::STATUS_W-1:0]  status;
  logic [sqlsel_pkg::MASK_W-1:0]    expected_mask;

  modport source (output valid, status, expected_mask, input ready);
  modport sink (input valid, status, expected_mask, output ready);
endinterface

>>> hdl/sql_select_token_recognizer.sv
// Top level of the SELECT statement token recognizer.
// A token item is held in the input register; its result item is registered in the result register.
// Throughput: one token item per cycle while results.ready is high; the input register and the result register
// each hold one item, and the grammar state updates as an item moves into the result register.
// Reset (rst, synchronous, active high) empties both registers and returns the recognizer to
// idle with bracket depth zero.
`timescale 1ns / 1ps
module sql_select_token_recognizer (
  input  logic                clk,
  input  logic                rst,
  sqlsel_tok_if.sink          tokens,
  sqlsel_res_if.source        results
);

  logic                                in_valid;
  logic [sqlsel_pkg::KIND_W-1:0]       in_kind;
  logic                                in_first;

  sqlsel_pkg::pos_t                    pos;
  sqlsel_pkg::pos_t                    pos_next;
  logic [sqlsel_pkg::DEPTH_W-1:0]      depth;
  logic [sqlsel_pkg::DEPTH_W-1:0]      depth_next;

  logic                                out_valid;
  sqlsel_pkg::status_t                 out_status;
  sqlsel_pkg::status_t                 out_status_next;
  logic [sqlsel_pkg::MASK_W-1:0]       out_mask;
  logic [sqlsel_pkg::MASK_W-1:0]       out_mask_next;

  logic                                advance;
  sqlsel_pkg::pos_t                    cur_pos;
  logic [sqlsel_pkg::DEPTH_W-1:0]      cur_depth;
  sqlsel_pkg::trans_t                  step;
  sqlsel_pkg::trans_t                  probe;

  assign advance = in_valid && (!out_valid || results.ready);
  assign tokens.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tokens.ready) begin
      in_valid <= tokens.valid;
    end
    if (tokens.ready && tokens.valid) begin
      in_kind  <= tokens.token_kind;
      in_first <= tokens.first_of_statement;
    end
  end

  always_comb begin
    cur_pos   = in_first ? sqlsel_pkg::P_START : pos;
    cur_depth = in_first ? '0 : depth;
    step      = sqlsel_pkg::trans(cur_pos, in_kind, cur_depth != '0);

    out_mask_next = '0;
    probe         = step;
    for (int j = 0; j < sqlsel_pkg::NUM_KINDS; j++) begin
      probe = sqlsel_pkg::trans(cur_pos, sqlsel_pkg::KIND_W'(j), cur_depth != '0);
      out_mask_next[j] = probe.act != sqlsel_pkg::ACT_NONE;
    end

    pos_next        = cur_pos;
    depth_next      = cur_depth;
    out_status_next = sqlsel_pkg::ST_CONTINUE;
    if (cur_pos == sqlsel_pkg::P_IDLE) begin
      out_status_next = sqlsel_pkg::ST_IDLE;
      out_mask_next   = '0;
    end else begin
      case (step.act)
        sqlsel_pkg::ACT_NONE: begin
          out_status_next = sqlsel_pkg::ST_ERROR;
          pos_next        = sqlsel_pkg::P_IDLE;
          depth_next      = '0;
        end
        sqlsel_pkg::ACT_ACCEPT: begin
          out_status_next = sqlsel_pkg::ST_ACCEPTED;
          pos_next        = sqlsel_pkg::P_IDLE;
          depth_next      = '0;
        end
        sqlsel_pkg::ACT_OPEN: begin
          if (cur_depth >= sqlsel_pkg::DEPTH_W'(sqlsel_pkg::MAX_NESTING)) begin
            out_status_next = sqlsel_pkg::ST_TOO_DEEP;
            pos_next        = sqlsel_pkg::P_IDLE;
            depth_next      = '0;
          end else begin
            pos_next   = sqlsel_pkg::P_OPEN;
            depth_next = cur_depth + 1'b1;
          end
        end
        sqlsel_pkg::ACT_CLOSE: begin
          pos_next   = sqlsel_pkg::P_CLOSED;
          depth_next = cur_depth - 1'b1;
        end
        default: begin
          pos_next = step.nxt;
        end
      endcase
      if (out_status_next != sqlsel_pkg::ST_ERROR) begin
        out_mask_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= sqlsel_pkg::P_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        pos       <= pos_next;
        depth     <= depth_next;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_status <= out_status_next;
      out_mask   <= out_mask_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_status;
  assign results.expected_mask = out_mask;

endmodule

>>> hdl/sqlsel_checker.sv
// Port-level assertions for the SELECT token recognizer and the bind that attaches them.
`timescale 1ns / 1ps
module sqlsel_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sqlsel_pkg::STATUS_W-1:0]  status,
  input logic [sqlsel_pkg::MASK_W-1:0]    expected_mask
);

  // Only a syntax error carries an expected mask.
  a_mask_only_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sqlsel_pkg::ST_ERROR |-> expected_mask == '0)
    else $error("expected_mask is nonzero on a result that is not a syntax error");

  // Every grammar position accepts some kind, so an error always names one.
  a_error_has_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sqlsel_pkg::ST_ERROR |-> expected_mask != '0)
    else $error("syntax error reported with an empty expected_mask");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(expected_mask))
    else $error("result item changed while stalled");

  // With nothing waiting at the output, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("token input blocked while the result register is empty");

  // A fresh result comes from a token item that was accepted into the input register.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item appeared without a matching accepted token item");

endmodule

bind sql_select_token_recognizer sqlsel_checker u_sqlsel_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (tokens.valid),
  .in_ready      (tokens.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .status        (results.status),
  .expected_mask (results.expected_mask)
);
